// File: rtl/fbea_pkg.sv
// ----------------------------------------------------------------------------
// Five-bar elbow angle package
// Shared widths, constants, the arc tangent table and small helpers.
// ----------------------------------------------------------------------------
package fbea_pkg;

	localparam int CordicStepsDefault = 16;
	localparam int CordicStepsMax = 32;

	// Internal datapath width for rotation cells.
	localparam int DW = 64;

	localparam logic signed [DW-1:0] KINV_Q30 = 64'sd652032874;
	localparam logic signed [DW-1:0] DEG_TO_RAD = 64'sd146409;
	localparam logic signed [DW-1:0] HALF_PI_Q30 = 64'sd1686629713;
	localparam logic signed [19:0] TURN_Q7 = 20'sd46080;
	localparam logic signed [19:0] HALF_TURN_Q7 = 20'sd23040;
	localparam logic signed [19:0] QUARTER_TURN_Q7 = 20'sd11520;

	// Register indexes.
	typedef enum logic [2:0] {
		REG_SPACING = 3'd0,
		REG_PROX1 = 3'd1,
		REG_PROX2 = 3'd2,
		REG_DIST1 = 3'd3,
		REG_DIST2 = 3'd4
	} reg_idx_t;

	// Cell operating mode.
	typedef enum logic {
		MODE_ROTATE = 1'b0,
		MODE_VECTOR = 1'b1
	} cordic_mode_t;

	// Arc tangent of 2^-i with 30 fraction bits.
	function automatic logic signed [DW-1:0] atan_entry(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h3243F6A8;
			1: v = 32'h1DAC6705;
			2: v = 32'h0FADBAFC;
			3: v = 32'h07F56EA6;
			4: v = 32'h03FEAB76;
			5: v = 32'h01FFD55B;
			6: v = 32'h00FFFAAA;
			7: v = 32'h007FFF55;
			8: v = 32'h003FFFEA;
			9: v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			24: v = 32'h0000003F;
			25: v = 32'h0000001F;
			26: v = 32'h0000000F;
			27: v = 32'h00000008;
			28: v = 32'h00000004;
			29: v = 32'h00000002;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return {32'd0, v};
	endfunction

	// Signed 32 by 32 product with a full 64-bit result.
	function automatic logic signed [DW-1:0] mul32(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return DW'(a) * DW'(b);
	endfunction

endpackage

// File: rtl/fbea_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation, rotating or vectoring, with a registered output.
// ----------------------------------------------------------------------------
module fbea_cell import fbea_pkg::*; #(
	parameter int Shift = 0
) (
	input  logic                 clk,
	input  cordic_mode_t         mode,
	input  logic signed [DW-1:0] x_in,
	input  logic signed [DW-1:0] y_in,
	input  logic signed [DW-1:0] z_in,
	output logic signed [DW-1:0] x_out,
	output logic signed [DW-1:0] y_out,
	output logic signed [DW-1:0] z_out
);

	logic signed [DW-1:0] dx, dy, at;
	logic                 up;

	assign dx = y_in >>> Shift;
	assign dy = x_in >>> Shift;
	assign at = atan_entry(Shift);

	// Direction: rotation follows z, vectoring drives y toward zero.
	always_comb begin
		if (mode == MODE_ROTATE) begin
			up = (z_in >= 0);
		end else begin
			up = !(y_in > 0);
		end
	end

	always_ff @(posedge clk) begin
		if (up) begin
			x_out <= x_in - dx;
			y_out <= y_in + dy;
			z_out <= z_in - at;
		end else begin
			x_out <= x_in + dx;
			y_out <= y_in - dy;
			z_out <= z_in + at;
		end
	end

endmodule

// File: rtl/fbea_chain.sv
// ----------------------------------------------------------------------------
// CORDIC chain
// A row of cells, one per iteration, taking a new vector every cycle.
// ----------------------------------------------------------------------------
module fbea_chain import fbea_pkg::*; #(
	parameter int Steps = CordicStepsDefault,
	parameter cordic_mode_t Mode = MODE_ROTATE
) (
	input  logic                 clk,
	input  logic signed [DW-1:0] x_in,
	input  logic signed [DW-1:0] y_in,
	input  logic signed [DW-1:0] z_in,
	output logic signed [DW-1:0] x_out,
	output logic signed [DW-1:0] y_out,
	output logic signed [DW-1:0] z_out
);

	logic signed [DW-1:0] xs [Steps+1];
	logic signed [DW-1:0] ys [Steps+1];
	logic signed [DW-1:0] zs [Steps+1];

	assign xs[0] = x_in;
	assign ys[0] = y_in;
	assign zs[0] = z_in;

	// One cell per iteration.
	for (genvar i = 0; i < Steps; i++) begin : g_cell
		fbea_cell #(.Shift(i)) u_cell (
			.clk  (clk),
			.mode (Mode),
			.x_in (xs[i]),
			.y_in (ys[i]),
			.z_in (zs[i]),
			.x_out(xs[i+1]),
			.y_out(ys[i+1]),
			.z_out(zs[i+1])
		);
	end

	assign x_out = xs[Steps];
	assign y_out = ys[Steps];
	assign z_out = zs[Steps];

endmodule

// File: rtl/fbea_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined square root
// Integer square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module fbea_isqrt import fbea_pkg::*; (
	input  logic        clk,
	input  logic [63:0] val,
	output logic [31:0] root
);

	logic [63:0] rem [33];
	logic [31:0] res [33];

	assign rem[0] = val;
	assign res[0] = '0;

	// Each stage decides one root bit, most significant first.
	for (genvar k = 0; k < 32; k++) begin : g_stage
		localparam int B = 31 - k;
		logic [63:0] trial;
		assign trial = ({32'd0, res[k]} << (B + 1)) + (64'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (rem[k] >= trial) begin
				rem[k+1] <= rem[k] - trial;
				res[k+1] <= res[k] | (32'd1 << B);
			end else begin
				rem[k+1] <= rem[k];
				res[k+1] <= res[k];
			end
		end
	end

	assign root = res[32];

endmodule

// File: rtl/five_bar_elbow_angle_unit.sv
// Throughput: one item per cycle; every stage is a register in a fixed pipeline.
// The three CORDIC cell rows, the square-root row and the registered stages between them set the latency.
// Reset clears the valid pipe and loads the register reset values.
// Results appear for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Five-bar elbow angle unit
// Elbow joint angle of a five-bar linkage from two motor angles.
// ----------------------------------------------------------------------------
module five_bar_elbow_angle_unit import fbea_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [16:0] drive_angle,
	input  logic signed [16:0] other_motor_angle,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic signed [16:0] elbow_angle,
	output logic               unreachable
);

	localparam int N = (CORDIC_STEPS > CordicStepsMax) ? CordicStepsMax : CORDIC_STEPS;
	localparam int LAT = 3 * N + 40;

	logic [15:0] spacing_q, prox1_q, prox2_q, dist1_q, dist2_q;
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= 16'd517;
			prox1_q <= 16'd4306;
			prox2_q <= 16'd4306;
			dist1_q <= 16'd4375;
			dist2_q <= 16'd4375;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPACING: spacing_q <= cfg_data;
				REG_PROX1: prox1_q <= cfg_data;
				REG_PROX2: prox2_q <= cfg_data;
				REG_DIST1: dist1_q <= cfg_data;
				REG_DIST2: dist2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid pipe that marks each beat in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end
	assign done = vld_q[LAT-1];

	// Range reduction to [-90, 90] degrees.
	function automatic logic [20:0] reduce(input logic signed [16:0] a);
		logic signed [19:0] r;
		logic               n;
		r = 20'(signed'(a));
		if (r < 0) r = r + TURN_Q7;
		if (r >= TURN_Q7) r = r - TURN_Q7;
		if (r >= HALF_TURN_Q7) r = r - TURN_Q7;
		n = 1'b0;
		if (r > QUARTER_TURN_Q7) begin
			r = r - HALF_TURN_Q7;
			n = 1'b1;
		end else if (r < -QUARTER_TURN_Q7) begin
			r = r + HALF_TURN_Q7;
			n = 1'b1;
		end
		return {n, r};
	endfunction

	// Stage 1: reduce and convert to radians.
	logic signed [DW-1:0] z1_s1, z2_s1, drv_s1;
	logic                 n1_s1, n2_s1;
	logic [20:0]          r1, r2;
	assign r1 = reduce(drive_angle);
	assign r2 = reduce(other_motor_angle);
	always_ff @(posedge clk) begin
		z1_s1 <= mul32(32'(signed'(r1[19:0])), DEG_TO_RAD[31:0]);
		z2_s1 <= mul32(32'(signed'(r2[19:0])), DEG_TO_RAD[31:0]);
		n1_s1 <= r1[20];
		n2_s1 <= r2[20];
		drv_s1 <= mul32(32'(drive_angle), DEG_TO_RAD[31:0]);
	end

	// Sine and cosine rows.
	logic signed [DW-1:0] c1, s1, c2, s2, zu1, zu2;
	fbea_chain #(.Steps(N), .Mode(MODE_ROTATE)) u_sc1 (
		.clk(clk), .x_in(KINV_Q30), .y_in('0), .z_in(z1_s1),
		.x_out(c1), .y_out(s1), .z_out(zu1));
	fbea_chain #(.Steps(N), .Mode(MODE_ROTATE)) u_sc2 (
		.clk(clk), .x_in(KINV_Q30), .y_in('0), .z_in(z2_s1),
		.x_out(c2), .y_out(s2), .z_out(zu2));

	// Side data delayed along the sine and cosine rows.
	logic [N-1:0]         n1_d, n2_d;
	logic signed [DW-1:0] drv_d [N];
	always_ff @(posedge clk) begin
		n1_d <= {n1_d[N-2:0], n1_s1};
		n2_d <= {n2_d[N-2:0], n2_s1};
		drv_d[0] <= drv_s1;
		for (int i = 1; i < N; i++) drv_d[i] <= drv_d[i-1];
	end

	// Stage 2: products of link lengths with sine and cosine.
	logic signed [DW-1:0] pc1_s2, ps1_s2, pc2_s2, ps2_s2, drv_s2;
	logic signed [DW-1:0] c1n, s1n, c2n, s2n;
	assign c1n = n1_d[N-1] ? -c1 : c1;
	assign s1n = n1_d[N-1] ? -s1 : s1;
	assign c2n = n2_d[N-1] ? -c2 : c2;
	assign s2n = n2_d[N-1] ? -s2 : s2;
	always_ff @(posedge clk) begin
		pc1_s2 <= mul32(32'(prox1_q), c1n[31:0]) >>> 22;
		ps1_s2 <= mul32(32'(prox1_q), s1n[31:0]) >>> 22;
		pc2_s2 <= mul32(32'(prox2_q), c2n[31:0]) >>> 22;
		ps2_s2 <= mul32(32'(prox2_q), s2n[31:0]) >>> 22;
		drv_s2 <= drv_d[N-1];
	end

	// Stage 3: pivot vector and quadrant fold.
	logic signed [DW-1:0] qx, qy, fx_s3, fy_s3, fz_s3, drv_s3;
	logic                 zero_s3;
	assign qx = pc1_s2 + (DW'(spacing_q) <<< 9) - pc2_s2;
	assign qy = ps1_s2 - ps2_s2;
	always_ff @(posedge clk) begin
		zero_s3 <= (qx == 0) && (qy == 0);
		drv_s3 <= drv_s2;
		if (qx < 0 && qy >= 0) begin
			fx_s3 <= qy; fy_s3 <= -qx; fz_s3 <= HALF_PI_Q30;
		end else if (qx < 0) begin
			fx_s3 <= -qy; fy_s3 <= qx; fz_s3 <= -HALF_PI_Q30;
		end else begin
			fx_s3 <= qx; fy_s3 <= qy; fz_s3 <= '0;
		end
	end

	// Vectoring row for angle and length.
	logic signed [DW-1:0] vx, vy, vz;
	fbea_chain #(.Steps(N), .Mode(MODE_VECTOR)) u_vec (
		.clk(clk), .x_in(fx_s3), .y_in(fy_s3), .z_in(fz_s3),
		.x_out(vx), .y_out(vy), .z_out(vz));

	logic [N-1:0]         zero_d;
	logic signed [DW-1:0] drv_e [N];
	always_ff @(posedge clk) begin
		zero_d <= {zero_d[N-2:0], zero_s3};
		drv_e[0] <= drv_s3;
		for (int i = 1; i < N; i++) drv_e[i] <= drv_e[i-1];
	end

	// Stage 4: gain correction product.
	logic signed [DW-1:0] mp_s4, ang_s4, drv_s4;
	always_ff @(posedge clk) begin
		mp_s4 <= zero_d[N-1] ? '0 : mul32(vx[31:0], KINV_Q30[31:0]);
		ang_s4 <= zero_d[N-1] ? '0 : vz;
		drv_s4 <= drv_e[N-1];
	end

	// Stage 5: sum and difference with the distal link.
	logic signed [DW-1:0] sum_s5, dif_s5, d2_s5, ang_s5, drv_s5, nm;
	assign nm = mp_s4 >>> 30;
	always_ff @(posedge clk) begin
		sum_s5 <= nm + (DW'(dist1_q) <<< 8);
		dif_s5 <= nm - (DW'(dist1_q) <<< 8);
		d2_s5 <= DW'(dist2_q) <<< 8;
		ang_s5 <= ang_s4;
		drv_s5 <= drv_s4;
	end

	// Stage 6: squares.
	logic signed [DW-1:0] ss_s6, dd_s6, d2sq_s6, ang_s6, drv_s6;
	always_ff @(posedge clk) begin
		ss_s6 <= mul32(sum_s5[31:0], sum_s5[31:0]);
		dd_s6 <= mul32(dif_s5[31:0], dif_s5[31:0]);
		d2sq_s6 <= mul32(d2_s5[31:0], d2_s5[31:0]);
		ang_s6 <= ang_s5;
		drv_s6 <= drv_s5;
	end

	// Stage 7: ratio terms, sign check and folding.
	logic signed [DW-1:0] num, den, num_s7, den_s7, ang_s7, drv_s7;
	logic                 bad_s7;
	assign num = ss_s6 - d2sq_s6;
	assign den = d2sq_s6 - dd_s6;
	always_ff @(posedge clk) begin
		bad_s7 <= (den == 0) || (num < 0 && den > 0) || (num > 0 && den < 0);
		num_s7 <= (num < 0) ? -num : num;
		den_s7 <= (num < 0) ? -den : den;
		ang_s7 <= ang_s6;
		drv_s7 <= drv_s6;
	end

	// Square roots of numerator and denominator.
	logic [31:0] rn, rd;
	fbea_isqrt u_sqn (.clk(clk), .val(num_s7), .root(rn));
	fbea_isqrt u_sqd (.clk(clk), .val(den_s7), .root(rd));

	logic [31:0]          bad_d;
	logic signed [DW-1:0] base_d [32];
	always_ff @(posedge clk) begin
		bad_d <= {bad_d[30:0], bad_s7};
		base_d[0] <= ang_s7 - drv_s7;
		for (int i = 1; i < 32; i++) base_d[i] <= base_d[i-1];
	end

	// Half-angle row: rd and rn are non-negative, no fold needed.
	logic signed [DW-1:0] hx, hy, phi;
	fbea_chain #(.Steps(N), .Mode(MODE_VECTOR)) u_half (
		.clk(clk), .x_in(DW'(rd)), .y_in(DW'(rn)), .z_in('0),
		.x_out(hx), .y_out(hy), .z_out(phi));

	logic [N-1:0]         bad_e;
	logic signed [DW-1:0] base_e [N];
	always_ff @(posedge clk) begin
		bad_e <= {bad_e[N-2:0], bad_d[31]};
		base_e[0] <= base_d[31];
		for (int i = 1; i < N; i++) base_e[i] <= base_e[i-1];
	end

	// Zero vector gives angle zero in the half-angle row.
	logic                 hz;
	logic [N-1:0]         hz_d;
	always_ff @(posedge clk) hz_d <= {hz_d[N-2:0], (rn == 0) && (rd == 0)};
	assign hz = hz_d[N-1];

	// Output stage: combine, round, saturate.
	logic signed [DW-1:0] th, q12;
	assign th = base_e[N-1] + (hz ? '0 : (phi <<< 1)) + (DW'(1) <<< 17);
	assign q12 = th >>> 18;
	always_ff @(posedge clk) begin
		unreachable <= bad_e[N-1];
		if (bad_e[N-1]) elbow_angle <= '0;
		else if (q12 > 65535) elbow_angle <= 17'sd65535;
		else if (q12 < -65536) elbow_angle <= -17'sd65536;
		else elbow_angle <= q12[16:0];
	end

	logic unused_ok;
	assign unused_ok = ^{zu1, zu2, vy, hx, hy};

endmodule

// File: test/tb_five_bar_elbow_angle_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Five-bar elbow angle unit testbench
// Drives motor angle pairs with random gaps, predicts each elbow angle with
// an independent fixed point CORDIC model and checks every done beat.
// ----------------------------------------------------------------------------
module tb_five_bar_elbow_angle_unit;
	import fbea_pkg::*;

	localparam int Steps = 16;
	localparam int Latency = 3 * Steps + 40;
	localparam longint CycleLimit = 1500000;
	localparam longint KinvGain = 652032874;
	localparam longint DegToRad = 146409;
	localparam longint HalfPi = 1686629713;
	localparam longint FullTurn = 46080;
	localparam longint HalfTurn = 23040;
	localparam longint QuarterTurn = 11520;

	typedef struct packed {
		logic signed [16:0] drive;
		logic signed [16:0] other;
	} pose_t;

	typedef struct packed {
		logic signed [16:0] angle;
		logic               unreach;
	} elbow_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [16:0] drive_angle = '0;
	logic signed [16:0] other_motor_angle = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic done;
	logic signed [16:0] elbow_angle;
	logic unreachable;

	// Link geometry as the predictor sees it.
	longint geo [5];
	pose_t pending_poses[$];
	elbow_t expected_elbows[$];
	int fail_count = 0;
	longint cycle_count = 0;
	bit hold_sender = 1'b0;

	five_bar_elbow_angle_unit #(.CORDIC_STEPS(Steps)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.drive_angle(drive_angle), .other_motor_angle(other_motor_angle),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .elbow_angle(elbow_angle), .unreachable(unreachable)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint atan_step(input int i);
		longint t [32] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
			64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
			64'h00000001, 64'h00000000};
		return t[i];
	endfunction

	// Cosine and sine of a degree angle, folded into a quarter turn first.
	function automatic void rotate_unit(input longint deg, output longint c,
			output longint s);
		longint r, x, y, z, dx, dy;
		bit flip;
		r = (deg + 2 * FullTurn) % FullTurn;
		flip = 1'b0;
		x = KinvGain;
		y = 0;
		if (r >= HalfTurn) r -= FullTurn;
		if (r > QuarterTurn) begin
			r -= HalfTurn;
			flip = 1'b1;
		end else if (r < -QuarterTurn) begin
			r += HalfTurn;
			flip = 1'b1;
		end
		z = r * DegToRad;
		for (int i = 0; i < Steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// Angle and corrected length of a vector; the zero vector gives zeros.
	function automatic void vector_polar(input longint xi, input longint yi,
			output longint ang, output longint mag);
		longint x, y, z, t, dx, dy;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) begin
			ang = 0;
			mag = 0;
			return;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HalfPi;
			end else begin
				x = -y; y = t; z = -HalfPi;
			end
		end
		for (int i = 0; i < Steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		ang = z;
		mag = (x * KinvGain) >>> 30;
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// Elbow angle of one pose under the current geometry.
	function automatic elbow_t solve_elbow(input pose_t p);
		longint c1, s1, c2, s2, qx, qy, ang, norm, phi, spare;
		longint d1, d2, sum, dif, num, den, theta, q12;
		elbow_t r;
		rotate_unit(longint'(p.drive), c1, s1);
		rotate_unit(longint'(p.other), c2, s2);
		qx = ((geo[REG_PROX1] * c1) >>> 22) + (geo[REG_SPACING] << 9)
			- ((geo[REG_PROX2] * c2) >>> 22);
		qy = ((geo[REG_PROX1] * s1) >>> 22) - ((geo[REG_PROX2] * s2) >>> 22);
		vector_polar(qx, qy, ang, norm);
		d1 = geo[REG_DIST1] << 8;
		d2 = geo[REG_DIST2] << 8;
		sum = norm + d1;
		dif = norm - d1;
		num = sum * sum - d2 * d2;
		den = d2 * d2 - dif * dif;
		if (den == 0 || (num < 0 && den > 0) || (num > 0 && den < 0)) begin
			r.angle = '0;
			r.unreach = 1'b1;
			return r;
		end
		if (num < 0) begin
			num = -num;
			den = -den;
		end
		vector_polar(int_sqrt(den), int_sqrt(num), phi, spare);
		theta = ang - longint'(p.drive) * DegToRad + 2 * phi;
		q12 = (theta + (64'sd1 << 17)) >>> 18;
		if (q12 > 65535) q12 = 65535;
		if (q12 < -65536) q12 = -65536;
		r.angle = q12[16:0];
		r.unreach = 1'b0;
		return r;
	endfunction

	// Driver: one pending pose per beat, with random gaps.
	always @(negedge clk) begin
		int gap;
		if (arst_n && !hold_sender && pending_poses.size() > 0 && (!start || !busy)) begin
			gap = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 19) == 0 ?
				$urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
			// Drop start during the gap so the last beat is not taken again.
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			if (!hold_sender && pending_poses.size() > 0) begin
				drive_angle <= pending_poses[0].drive;
				other_motor_angle <= pending_poses[0].other;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end else if (start && !busy) begin
			start <= 1'b0;
		end
	end

	// Accept on the rising edge; predict at acceptance.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			expected_elbows.push_back(solve_elbow(pending_poses.pop_front()));
		end
	end

	// Monitor: compare each done beat with the oldest prediction.
	always @(posedge clk) begin
		elbow_t e;
		cycle_count <= cycle_count + 1;
		if (arst_n && done) begin
			if (expected_elbows.size() == 0) begin
				$error("unexpected result beat");
				fail_count++;
			end else begin
				e = expected_elbows.pop_front();
				if (elbow_angle !== e.angle) begin
					$error("elbow_angle expected %0d actual %0d", e.angle, elbow_angle);
					fail_count++;
				end
				if (unreachable !== e.unreach) begin
					$error("unreachable expected %0d actual %0d", e.unreach, unreachable);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic add_pose(input logic signed [16:0] a, input logic signed [16:0] b);
		pose_t p;
		p.drive = a;
		p.other = b;
		pending_poses.push_back(p);
	endtask

	function automatic logic signed [16:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 17'(int'($urandom_range(0, 92160)) - 46080);
			1: return $urandom_range(0, 1) ? 17'sd46080 : -17'sd46080;
			2: return 17'($urandom);
			default: return 17'(int'($urandom_range(0, 23040)) - 11520);
		endcase
	endfunction

	// Wait until every beat sent so far has come back, then let the pipe drain.
	task automatic drain();
		while (pending_poses.size() > 0 || expected_elbows.size() > 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		geo[idx] = longint'(v);
	endtask

	task automatic write_geometry(input logic [15:0] sp, input logic [15:0] p1,
			input logic [15:0] p2, input logic [15:0] d1, input logic [15:0] d2);
		write_reg(REG_SPACING, sp);
		write_reg(REG_PROX1, p1);
		write_reg(REG_PROX2, p2);
		write_reg(REG_DIST1, d1);
		write_reg(REG_DIST2, d2);
	endtask

	initial begin
		geo[REG_SPACING] = 517;
		geo[REG_PROX1] = 4306;
		geo[REG_PROX2] = 4306;
		geo[REG_DIST1] = 4375;
		geo[REG_DIST2] = 4375;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed poses: extremes, wraps past a half turn, folded poses.
		add_pose(0, 0);
		add_pose(17'sd46080, 17'sd46080);
		add_pose(-17'sd46080, -17'sd46080);
		add_pose(17'sd23040, 17'sd0);
		add_pose(17'sd11520, -17'sd11520);
		add_pose(-17'sd11521, 17'sd11521);
		add_pose(17'sd30000, -17'sd30000);
		add_pose(-17'sd65536, 17'sd65535);
		add_pose(17'sd65535, -17'sd65536);
		add_pose(17'sd5760, 17'sd17280);
		add_pose(17'sd17280, 17'sd5760);
		add_pose(17'sd1, -17'sd1);
		drain();

		// Equal links with no spacing: the pivots meet, a zero vector.
		write_geometry(16'd0, 16'd4000, 16'd4000, 16'd4375, 16'd4375);
		add_pose(17'sd11520, 17'sd11520);
		add_pose(17'sd0, 17'sd0);
		// Other motor at a half turn: the pivots stay within reach of the distal links.
		add_pose(17'sd0, 17'sd23040);
		drain();
		write_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_pose(17'sd0, 17'sd0);
		add_pose(17'sd46080, -17'sd23040);
		drain();
		write_geometry(16'd517, 16'd4306, 16'd4306, 16'd0, 16'd0);
		add_pose(17'sd100, 17'sd200);
		drain();
		write_geometry(16'd517, 16'd4306, 16'd4306, 16'd4375, 16'd4375);

		// Random phases under several geometries.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				if (ph == 5)
					write_geometry(16'd517, 16'd4306, 16'd4306, 16'd4375, 16'd4375);
				else
					write_geometry(16'($urandom_range(0, 2000)),
						16'($urandom_range(1000, 8000)), 16'($urandom_range(1000, 8000)),
						16'($urandom_range(1000, 9000)), 16'($urandom_range(1000, 9000)));
			end
			for (int k = 0; k < 220; k++) add_pose(rand_angle(), rand_angle());
			if (ph == 2) begin
				// Sender holds off until every outstanding beat has returned.
				while (pending_poses.size() > 110) @(posedge clk);
				hold_sender = 1'b1;
				while (expected_elbows.size() > 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/fbea_pkg.sv
rtl/fbea_cell.sv
rtl/fbea_chain.sv
rtl/fbea_isqrt.sv
rtl/five_bar_elbow_angle_unit.sv
test/tb_five_bar_elbow_angle_unit.sv
